/* rtl/advert_payload_parser_defines.svh */
// ----------------------------------------------------------------------------
// Advertisement payload parser: assertion macros
// Shared property wrappers, clocked on i_clk and disabled while in reset.
// ----------------------------------------------------------------------------
`ifndef ADVERT_PAYLOAD_PARSER_DEFINES_SVH
`define ADVERT_PAYLOAD_PARSER_DEFINES_SVH

// Same-cycle implication
`define ADVP_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define ADVP_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/advp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Advertisement payload parser package
// Result and configuration types, layout offsets, codes and defaults.
// ----------------------------------------------------------------------------
package advp_pkg;

    // Result kinds
    localparam logic [1:0] KIND_KEY    = 2'd0;
    localparam logic [1:0] KIND_BLOOM  = 2'd1;
    localparam logic [1:0] KIND_NAME   = 2'd2;
    localparam logic [1:0] KIND_STATUS = 2'd3;

    // Configuration register indexes
    localparam logic [1:0] CFG_ADVERT_TYPE = 2'd0;
    localparam logic [1:0] CFG_EXT_VERSION = 2'd1;
    localparam logic [1:0] CFG_BLOOM_WANT  = 2'd2;
    localparam logic [1:0] CFG_NAME_BUF    = 2'd3;

    // Payload layout
    localparam logic [7:0] KEY_LEN      = 8'd32;
    localparam logic [7:0] TIME_END     = 8'd36;
    localparam logic [7:0] FLAGS_OFFSET = 8'd100;
    localparam logic [7:0] MIN_LEN      = 8'd101;
    localparam logic [7:0] BLOOM_LEN    = 8'd32;
    localparam logic [7:0] POS_SKIP     = 8'd8;
    localparam logic [7:0] FEAT_SKIP    = 8'd2;
    localparam logic [7:0] PRINT_LO     = 8'd32;
    localparam logic [7:0] PRINT_HI     = 8'd126;

    // Flag bit positions
    localparam int FLAG_POSITION = 4;
    localparam int FLAG_BLOOM    = 5;
    localparam int FLAG_FEATURE  = 6;
    localparam int FLAG_NAME     = 7;

    // Defaults
    localparam int unsigned NAME_CAP_DEF = 32;
    localparam logic [3:0] RST_ADVERT_TYPE = 4'd4;
    localparam logic [1:0] RST_EXT_VERSION = 2'd1;
    localparam logic       RST_BLOOM_WANT  = 1'b1;
    localparam logic [7:0] RST_NAME_BUF    = 8'd33;

    typedef struct packed {
        logic [3:0] advert_type_code;
        logic [1:0] extended_version_code;
        logic       bloom_wanted;
        logic [7:0] name_buffer_size;
    } t_cfg;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  data;
        logic [7:0]  index;
        logic [31:0] timestamp;
        logic        status;
        logic        bloom_present;
        logic [7:0]  name_length;
        logic        last;
    } t_result;

endpackage

/* rtl/advp_parse.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Advertisement payload parser: byte decoder
// Holds the per-packet state and turns each accepted byte into up to two
// results (a data byte and the final status).
// ----------------------------------------------------------------------------
module advp_parse #(
    parameter int unsigned NAME_CAP = advp_pkg::NAME_CAP_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  advp_pkg::t_cfg      i_cfg,
    input  logic [7:0]          i_data_byte,
    input  logic                i_first,
    input  logic [7:0]          i_pkt_len,
    input  logic [3:0]          i_pkt_type,
    input  logic [1:0]          i_version,
    output logic [1:0]          o_push_cnt,
    output advp_pkg::t_result   o_item0,
    output advp_pkg::t_result   o_item1
);
    import advp_pkg::*;

    localparam logic [7:0] CAP = 8'(NAME_CAP);

    logic [7:0]  r_pos, r_flags, r_bstart, r_nstart, r_nwr;
    logic [31:0] r_time;
    logic        r_err, r_bem;
    logic [7:0]  n_pos, n_flags, n_bstart, n_nstart, n_nwr;
    logic [31:0] n_time;
    logic        n_err, n_bem;

    logic [7:0]  w_p, w_bs, w_ns, w_lim, w_room, w_rel, w_bend;
    logic        w_bad, w_has, w_end, w_hit, w_serr;
    logic [8:0]  w_bfit;
    t_result     w_dat, w_sts;

    // Decode one byte against the packet state
    always_comb begin
        // restart on a first byte
        n_pos    = i_first ? '0 : r_pos;
        n_flags  = i_first ? '0 : r_flags;
        n_bstart = i_first ? '0 : r_bstart;
        n_nstart = i_first ? '0 : r_nstart;
        n_nwr    = i_first ? '0 : r_nwr;
        n_time   = i_first ? '0 : r_time;
        n_err    = i_first ? 1'b0 : r_err;
        n_bem    = i_first ? 1'b0 : r_bem;
        w_p      = n_pos;

        w_bad  = (i_pkt_type != i_cfg.advert_type_code) || (i_pkt_len < MIN_LEN);
        w_bs   = FLAGS_OFFSET + 8'd1 + (i_data_byte[FLAG_POSITION] ? POS_SKIP : 8'd0);
        w_has  = i_data_byte[FLAG_BLOOM] && (i_version == i_cfg.extended_version_code);
        w_bfit = {1'b0, w_bs} + {1'b0, BLOOM_LEN};
        w_bend = n_bstart + BLOOM_LEN;

        // name length limit: raw length clamped to capacity and buffer room
        w_ns   = n_nstart;
        w_lim  = (i_pkt_len > w_ns) ? (i_pkt_len - w_ns) : 8'd0;
        w_room = (i_cfg.name_buffer_size != 8'd0) ? (i_cfg.name_buffer_size - 8'd1) : 8'd0;
        if (w_lim > CAP)    w_lim = CAP;
        if (w_lim > w_room) w_lim = w_room;
        w_rel  = w_p - w_ns;

        w_hit = 1'b0;
        w_dat = '0;

        if (!w_bad && !n_err) begin
            if (w_p < KEY_LEN) begin
                w_hit      = 1'b1;
                w_dat.kind = KIND_KEY;
                w_dat.data = i_data_byte;
                w_dat.index = w_p;
            end else if (w_p < TIME_END) begin
                case (w_p[1:0])
                    2'd0:    n_time[7:0]   = n_time[7:0]   | i_data_byte;
                    2'd1:    n_time[15:8]  = n_time[15:8]  | i_data_byte;
                    2'd2:    n_time[23:16] = n_time[23:16] | i_data_byte;
                    default: n_time[31:24] = n_time[31:24] | i_data_byte;
                endcase
            end else if (w_p == FLAGS_OFFSET) begin
                n_flags = i_data_byte;
                if (w_has && i_cfg.bloom_wanted) begin
                    if (w_bfit > {1'b0, i_pkt_len}) n_err = 1'b1;
                    else                            n_bem = 1'b1;
                end
                n_bstart = w_bs;
                n_nstart = w_bs + (w_has ? BLOOM_LEN : 8'd0)
                         + (i_data_byte[FLAG_FEATURE] ? FEAT_SKIP : 8'd0);
            end else if (w_p > FLAGS_OFFSET) begin
                if (n_bem && w_p >= n_bstart && w_p < w_bend) begin
                    w_hit       = 1'b1;
                    w_dat.kind  = KIND_BLOOM;
                    w_dat.data  = i_data_byte;
                    w_dat.index = w_p - n_bstart;
                end else if (n_flags[FLAG_NAME] && w_p >= w_ns) begin
                    if (w_rel < w_lim && i_data_byte >= PRINT_LO
                        && i_data_byte <= PRINT_HI) begin
                        w_hit       = 1'b1;
                        w_dat.kind  = KIND_NAME;
                        w_dat.data  = i_data_byte;
                        w_dat.index = n_nwr;
                        n_nwr       = n_nwr + 8'd1;
                    end
                end
            end
        end

        // final status on the last byte of the packet
        w_end  = ({1'b0, w_p} + 9'd1) >= {1'b0, i_pkt_len};
        w_serr = w_bad || n_err;
        w_sts  = '0;
        w_sts.kind          = KIND_STATUS;
        w_sts.timestamp     = w_bad ? 32'd0 : n_time;
        w_sts.status        = w_serr;
        w_sts.bloom_present = !w_serr && n_bem;
        w_sts.name_length   = w_serr ? 8'd0 : n_nwr;
        w_sts.last          = 1'b1;

        if (w_end) begin
            n_pos    = '0;
            n_flags  = '0;
            n_bstart = '0;
            n_nstart = '0;
            n_nwr    = '0;
            n_time   = '0;
            n_err    = 1'b0;
            n_bem    = 1'b0;
        end else begin
            n_pos = w_p + 8'd1;
        end
    end

    // Pack results, data item ahead of status
    always_comb begin
        o_item0 = w_hit ? w_dat : w_sts;
        o_item1 = w_sts;
        if (!i_accept) o_push_cnt = 2'd0;
        else           o_push_cnt = {1'b0, w_hit} + {1'b0, w_end};
    end

    // Hold packet state, advance on each accepted byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= '0;
            r_flags  <= '0;
            r_bstart <= '0;
            r_nstart <= '0;
            r_nwr    <= '0;
            r_time   <= '0;
            r_err    <= 1'b0;
            r_bem    <= 1'b0;
        end else if (i_accept) begin
            r_pos    <= n_pos;
            r_flags  <= n_flags;
            r_bstart <= n_bstart;
            r_nstart <= n_nstart;
            r_nwr    <= n_nwr;
            r_time   <= n_time;
            r_err    <= n_err;
            r_bem    <= n_bem;
        end
    end

endmodule

/* rtl/advp_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Advertisement payload parser: result queue
// Four-entry result buffer taking up to two results per cycle and handing
// out one while ready is high; signals room while at least two entries are free.
// ----------------------------------------------------------------------------
module advp_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [1:0]        i_push_cnt,
    input  advp_pkg::t_result i_item0,
    input  advp_pkg::t_result i_item1,
    output logic              o_room,
    output logic              o_valid,
    input  logic              i_ready,
    output advp_pkg::t_result o_item
);
    import advp_pkg::*;

    localparam int DEPTH = 4;

    t_result    r_mem [DEPTH];
    logic [1:0] r_head, r_tail;
    logic [2:0] r_count;
    logic [1:0] n_head, n_tail;
    logic [2:0] n_count;
    logic       w_pop;

    assign w_pop   = o_valid && i_ready;
    assign o_valid = (r_count != 3'd0);
    assign o_room  = (r_count <= 3'd2);
    assign o_item  = r_mem[r_head];

    // Advance pointers and fill count
    always_comb begin
        n_head  = r_head + {1'b0, w_pop};
        n_tail  = r_tail + i_push_cnt;
        n_count = r_count + {1'b0, i_push_cnt} - {2'b0, w_pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
        end
    end

    // Store incoming results
    always_ff @(posedge i_clk) begin
        if (i_push_cnt != 2'd0) r_mem[r_tail] <= i_item0;
        if (i_push_cnt == 2'd2) r_mem[r_tail + 2'd1] <= i_item1;
    end

`include "advert_payload_parser_defines.svh"

    `ADVP_ASSERT_IMP(a_count_bound, 1'b1, r_count <= 3'(DEPTH), "queue count over depth")
    `ADVP_ASSERT_IMP(a_push_room, i_push_cnt != 2'd0, r_count <= 3'd2, "push without room")
    `ADVP_ASSERT_NXT(a_pop_only, w_pop && i_push_cnt == 2'd0, r_count == $past(r_count) - 3'd1, "pop miscounted")
    `ADVP_ASSERT_IMP(a_ptr_gap, 1'b1, r_tail == r_head + r_count[1:0], "pointers disagree with count")

endmodule

/* rtl/advert_payload_parser.sv */
`timescale 1ns / 1ps
// Results: an accepted byte's results are registered in the result queue and offered from it in order.
// Throughput: one payload byte per cycle, set by the four-entry result queue;
// a byte that ends a packet can queue a data result and the status together,
// and ready drops only while fewer than two queue entries are free.
// Reset: synchronous, active low; clears packet state and the result queue,
// and returns the configuration registers to their defaults.
// ----------------------------------------------------------------------------
// Advertisement payload parser
// Decodes advertisement payload bytes into key, bloom and name results and
// a final status per packet.
// ----------------------------------------------------------------------------
module advert_payload_parser #(
    parameter int unsigned NAME_CAP = advp_pkg::NAME_CAP_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration writes
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data,
    // byte requests
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_first,
    input  logic [7:0]  i_pkt_len,
    input  logic [3:0]  i_pkt_type,
    input  logic [1:0]  i_version,
    // result requests
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_kind,
    output logic [7:0]  o_data,
    output logic [7:0]  o_index,
    output logic [31:0] o_timestamp,
    output logic        o_status,
    output logic        o_bloom_present,
    output logic [7:0]  o_name_length,
    output logic        o_last
);
    import advp_pkg::*;

    t_cfg       r_cfg;
    logic       w_accept, w_room;
    logic [1:0] w_push_cnt;
    t_result    w_item0, w_item1, w_out;

    assign o_cfg_ready = 1'b1;
    assign o_ready     = w_room;
    assign w_accept    = i_valid && w_room;

    // Hold configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.advert_type_code      <= RST_ADVERT_TYPE;
            r_cfg.extended_version_code <= RST_EXT_VERSION;
            r_cfg.bloom_wanted          <= RST_BLOOM_WANT;
            r_cfg.name_buffer_size      <= RST_NAME_BUF;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_ADVERT_TYPE: r_cfg.advert_type_code      <= i_cfg_data[3:0];
                CFG_EXT_VERSION: r_cfg.extended_version_code <= i_cfg_data[1:0];
                CFG_BLOOM_WANT:  r_cfg.bloom_wanted          <= i_cfg_data[0];
                CFG_NAME_BUF:    r_cfg.name_buffer_size      <= i_cfg_data;
                default: ;
            endcase
        end
    end

    advp_parse #(
        .NAME_CAP (NAME_CAP)
    ) u_parse (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (w_accept),
        .i_cfg          (r_cfg),
        .i_data_byte    (i_data_byte),
        .i_first        (i_first),
        .i_pkt_len      (i_pkt_len),
        .i_pkt_type     (i_pkt_type),
        .i_version      (i_version),
        .o_push_cnt     (w_push_cnt),
        .o_item0        (w_item0),
        .o_item1        (w_item1)
    );

    advp_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push_cnt (w_push_cnt),
        .i_item0    (w_item0),
        .i_item1    (w_item1),
        .o_room     (w_room),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_item     (w_out)
    );

    // Drive result fields
    assign o_kind          = w_out.kind;
    assign o_data          = w_out.data;
    assign o_index         = w_out.index;
    assign o_timestamp     = w_out.timestamp;
    assign o_status        = w_out.status;
    assign o_bloom_present = w_out.bloom_present;
    assign o_name_length   = w_out.name_length;
    assign o_last          = w_out.last;

endmodule

/* dv/advert_payload_parser_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Advertisement payload parser testbench
// Streams payload bytes through the parser under random backpressure on both
// channels and checks every key, bloom, name and status result against a
// cycle-free decoder of the payload layout, across several register settings.
// ----------------------------------------------------------------------------
module advert_payload_parser_test;

    import advp_pkg::*;

    localparam int NAME_CAP     = NAME_CAP_DEF;
    localparam int RESET_CYCLES = 11;
    localparam int DRAIN_CYCLES = 4;
    localparam int END_CYCLES   = 10;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int PHASE_BYTES  = 90;
    localparam int HOLD_AT      = 60;
    localparam int HOLD_LEN     = 200;
    localparam int IDLE_PCT     = 7;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       first;
        logic [7:0] pkt_len;
        logic [3:0] pkt_type;
        logic [1:0] version;
    } t_ad_byte;

    // block ports
    logic        i_clk           = 1'b0;
    logic        i_rst_n         = 1'b0;
    logic        i_cfg_valid     = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index     = CFG_ADVERT_TYPE;
    logic [7:0]  i_cfg_data      = '0;
    logic        i_valid         = 1'b0;
    logic        o_ready;
    logic [7:0]  i_data_byte     = '0;
    logic        i_first         = 1'b0;
    logic [7:0]  i_pkt_len       = '0;
    logic [3:0]  i_pkt_type      = '0;
    logic [1:0]  i_version       = '0;
    logic        o_valid;
    logic        i_ready         = 1'b0;
    logic [1:0]  o_kind;
    logic [7:0]  o_data;
    logic [7:0]  o_index;
    logic [31:0] o_timestamp;
    logic        o_status;
    logic        o_bloom_present;
    logic [7:0]  o_name_length;
    logic        o_last;

    // stimulus and expectations
    t_ad_byte byte_queue[$];
    t_result  due_results[$];

    // decoder copy of registers and per-packet state
    t_cfg        cfg_q;
    logic [7:0]  pos_q;
    logic [7:0]  flags_q;
    logic [31:0] stamp_q;
    logic        err_q;
    logic        bloom_q;
    int          bloom_base;
    int          name_base;
    logic [7:0]  name_count;

    // bookkeeping
    int       cycle_count     = 0;
    int       bytes_taken     = 0;
    int       bytes_queued    = 0;
    int       results_checked = 0;
    int       statuses_seen   = 0;
    int       settings_used   = 1;
    int       errors          = 0;
    logic     byte_taken_now  = 1'b0;
    logic     steady;
    int       holdoff_left    = 0;
    logic     holdoff_done    = 1'b0;
    t_ad_byte next_byte;
    t_ad_byte sampled_byte;
    t_result  want;

    advert_payload_parser #(
        .NAME_CAP(NAME_CAP)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_data_byte    (i_data_byte),
        .i_first        (i_first),
        .i_pkt_len      (i_pkt_len),
        .i_pkt_type     (i_pkt_type),
        .i_version      (i_version),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_kind         (o_kind),
        .o_data         (o_data),
        .o_index        (o_index),
        .o_timestamp    (o_timestamp),
        .o_status       (o_status),
        .o_bloom_present(o_bloom_present),
        .o_name_length  (o_name_length),
        .o_last         (o_last)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // No idling on either side over this stretch of the run
    assign steady = (bytes_taken >= 300) && (bytes_taken < 500);

    // ------------------------------------------------------------------
    // Payload decoder
    // ------------------------------------------------------------------
    task automatic clear_packet_state();
        pos_q      = '0;
        flags_q    = '0;
        stamp_q    = '0;
        err_q      = 1'b0;
        bloom_q    = 1'b0;
        bloom_base = 0;
        name_base  = 0;
        name_count = '0;
    endtask

    task automatic push_data(input logic [1:0] kind, input logic [7:0] value, input int idx);
        t_result r;
        r       = '0;
        r.kind  = kind;
        r.data  = value;
        r.index = 8'(idx);
        due_results.push_back(r);
    endtask

    task automatic decode_byte(input t_ad_byte b);
        int      p;
        logic    bad;
        logic    bloom_here;
        int      bs;
        int      lim;
        int      room;
        t_result r;
        if (b.first)
            clear_packet_state();
        p   = pos_q;
        bad = (b.pkt_type != cfg_q.advert_type_code) || (b.pkt_len < MIN_LEN);

        if (!bad && !err_q) begin
            if (p < KEY_LEN) begin
                push_data(KIND_KEY, b.data_byte, p);
            end else if (p < TIME_END) begin
                stamp_q = stamp_q | (32'(b.data_byte) << (8 * (p - KEY_LEN)));
            end else if (p == FLAGS_OFFSET) begin
                // lay out the optional fields from the flags byte
                bs         = FLAGS_OFFSET + 1 + (b.data_byte[FLAG_POSITION] ? POS_SKIP : 0);
                flags_q    = b.data_byte;
                bloom_here = b.data_byte[FLAG_BLOOM] &&
                             (b.version == cfg_q.extended_version_code);
                if (bloom_here && cfg_q.bloom_wanted) begin
                    if (bs + BLOOM_LEN > b.pkt_len)
                        err_q = 1'b1;
                    else
                        bloom_q = 1'b1;
                end
                bloom_base = bs;
                name_base  = bs + (bloom_here ? BLOOM_LEN : 0) +
                             (b.data_byte[FLAG_FEATURE] ? FEAT_SKIP : 0);
            end else if (p > FLAGS_OFFSET) begin
                if (bloom_q && p >= bloom_base && p < bloom_base + BLOOM_LEN) begin
                    push_data(KIND_BLOOM, b.data_byte, p - bloom_base);
                end else if (flags_q[FLAG_NAME] && p >= name_base) begin
                    // clamp the name to the cap and the buffer room
                    lim  = (b.pkt_len > name_base) ? b.pkt_len - name_base : 0;
                    room = (cfg_q.name_buffer_size != 0) ? cfg_q.name_buffer_size - 1 : 0;
                    if (lim > NAME_CAP)
                        lim = NAME_CAP;
                    if (lim > room)
                        lim = room;
                    if (p - name_base < lim && b.data_byte >= PRINT_LO &&
                        b.data_byte <= PRINT_HI) begin
                        push_data(KIND_NAME, b.data_byte, name_count);
                        name_count = name_count + 8'd1;
                    end
                end
            end
        end

        // close the packet on its last byte
        if (p + 1 >= b.pkt_len) begin
            r               = '0;
            r.kind          = KIND_STATUS;
            r.timestamp     = bad ? 32'd0 : stamp_q;
            r.status        = bad || err_q;
            r.bloom_present = !(bad || err_q) && bloom_q;
            r.name_length   = (bad || err_q) ? 8'd0 : name_count;
            r.last          = 1'b1;
            due_results.push_back(r);
            clear_packet_state();
        end else begin
            pos_q = 8'(p + 1);
        end
    endtask

    task automatic compare_field(input string what, input logic [31:0] exp_v,
                                 input logic [31:0] act_v);
        if (exp_v !== act_v) begin
            errors++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, exp_v, act_v);
        end
    endtask

    // ------------------------------------------------------------------
    // Monitor: track registers, decode accepted bytes, check results
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        byte_taken_now = i_rst_n && i_valid && o_ready;
        if (!i_rst_n) begin
            cfg_q = '{RST_ADVERT_TYPE, RST_EXT_VERSION, RST_BLOOM_WANT, RST_NAME_BUF};
            clear_packet_state();
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_ADVERT_TYPE: cfg_q.advert_type_code      = i_cfg_data[3:0];
                    CFG_EXT_VERSION: cfg_q.extended_version_code = i_cfg_data[1:0];
                    CFG_BLOOM_WANT:  cfg_q.bloom_wanted          = i_cfg_data[0];
                    CFG_NAME_BUF:    cfg_q.name_buffer_size      = i_cfg_data;
                    default: ;
                endcase
            end

            if (byte_taken_now) begin
                bytes_taken++;
                sampled_byte = '{i_data_byte, i_first, i_pkt_len, i_pkt_type, i_version};
                decode_byte(sampled_byte);
            end

            if (o_valid && i_ready) begin
                if (due_results.size() == 0) begin
                    errors++;
                    $display("%0t: result with nothing expected, expected none, actual kind %0d data %0h",
                             $time, o_kind, o_data);
                end else begin
                    want = due_results.pop_front();
                    compare_field("kind", want.kind, o_kind);
                    compare_field("data", want.data, o_data);
                    compare_field("index", want.index, o_index);
                    compare_field("timestamp", want.timestamp, o_timestamp);
                    compare_field("status", want.status, o_status);
                    compare_field("bloom_present", want.bloom_present, o_bloom_present);
                    compare_field("name_length", want.name_length, o_name_length);
                    compare_field("last", want.last, o_last);
                    results_checked++;
                    if (want.kind == KIND_STATUS)
                        statuses_seen++;
                end
            end
        end
    end

    // Run limit
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles, %0d results still due", $time,
                     CYCLE_LIMIT, due_results.size());
            $display("[advert_payload_parser] ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Byte driver: hold an offered request until taken, idle at random
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (i_valid && !byte_taken_now) begin
            // hold the current request
        end else if (byte_queue.size() != 0 &&
                     (steady || $urandom_range(99) >= IDLE_PCT)) begin
            next_byte   = byte_queue.pop_front();
            i_valid     <= 1'b1;
            i_data_byte <= next_byte.data_byte;
            i_first     <= next_byte.first;
            i_pkt_len   <= next_byte.pkt_len;
            i_pkt_type  <= next_byte.pkt_type;
            i_version   <= next_byte.version;
        end else begin
            i_valid <= 1'b0;
        end
    end

    // Result receiver: random stalls plus one long hold-off
    always @(negedge i_clk) begin
        if (!holdoff_done && bytes_taken >= HOLD_AT) begin
            holdoff_left = HOLD_LEN;
            holdoff_done = 1'b1;
        end
        if (holdoff_left > 0) begin
            holdoff_left--;
            i_ready <= 1'b0;
        end else begin
            i_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // ------------------------------------------------------------------
    // Sequencing
    // ------------------------------------------------------------------
    task automatic add_byte(input logic [7:0] d, input logic first, input logic [7:0] plen,
                            input logic [3:0] ptype, input logic [1:0] ver);
        byte_queue.push_back('{d, first, plen, ptype, ver});
        bytes_queued++;
    endtask

    // Short packets: empty and one-byte packets, wrong type, restarts and
    // header changes that end a packet early
    task automatic queue_directed();
        add_byte(8'h00, 1'b1, 8'd0,   4'd4,  2'd0);
        add_byte(8'hFF, 1'b1, 8'd1,   4'd15, 2'd3);
        add_byte(8'hA5, 1'b1, 8'd2,   4'd4,  2'd1);
        add_byte(8'h5A, 1'b0, 8'd2,   4'd4,  2'd1);
        add_byte(8'h80, 1'b1, 8'd255, 4'd4,  2'd3);
        add_byte(8'h7F, 1'b0, 8'd255, 4'd4,  2'd2);
        add_byte(8'h01, 1'b0, 8'd255, 4'd0,  2'd1);
        add_byte(8'hFE, 1'b1, 8'd255, 4'd4,  2'd1);
        add_byte(8'h11, 1'b0, 8'd255, 4'd4,  2'd1);
        add_byte(8'h22, 1'b0, 8'd3,   4'd4,  2'd1);
        add_byte(8'h33, 1'b0, 8'd100, 4'd4,  2'd1);
        add_byte(8'h44, 1'b0, 8'd1,   4'd4,  2'd1);
        add_byte(8'hC3, 1'b1, 8'd128, 4'd4,  2'd1);
        add_byte(8'h3C, 1'b0, 8'd128, 4'd10, 2'd2);
        add_byte(8'h00, 1'b0, 8'd2,   4'd5,  2'd0);
    endtask

    // One packet: mostly well formed with random content, the rest cut,
    // mistyped, too short, abandoned or with a header change partway
    task automatic queue_packet();
        int         mode;
        int         plen;
        int         need;
        int         count;
        int         chg_at;
        int         chg_kind;
        int         alt_len;
        logic [7:0] flags;
        logic [3:0] ptype;
        logic [1:0] ver;
        logic       bloom_in;
        logic [7:0] d;
        mode     = $urandom_range(99);
        flags    = 8'($urandom);
        ptype    = cfg_q.advert_type_code;
        ver      = $urandom_range(1) ? cfg_q.extended_version_code : 2'($urandom);
        bloom_in = flags[FLAG_BLOOM] && (ver == cfg_q.extended_version_code);
        need     = MIN_LEN + (flags[FLAG_POSITION] ? POS_SKIP : 0) +
                   (bloom_in ? BLOOM_LEN : 0) + (flags[FLAG_FEATURE] ? FEAT_SKIP : 0);
        if (flags[FLAG_NAME])
            plen = need + (($urandom_range(3) == 0) ? $urandom_range(130) : $urandom_range(36));
        else
            plen = need + $urandom_range(3);
        if (plen > 255)
            plen = 255;
        count    = plen;
        chg_at   = 1000;
        chg_kind = 0;
        alt_len  = 0;

        if (mode >= 65 && mode < 75) begin
            // end inside the optional fields
            plen  = $urandom_range(need, MIN_LEN);
            count = plen;
        end else if (mode >= 75 && mode < 82) begin
            ptype = ptype + 4'($urandom_range(15, 1));
        end else if (mode >= 82 && mode < 89) begin
            plen  = $urandom_range(MIN_LEN - 1);
            count = (plen == 0) ? 1 : plen;
        end else if (mode >= 89 && mode < 95) begin
            count = $urandom_range(plen - 1, 1);
        end else if (mode >= 95) begin
            chg_at   = $urandom_range(plen - 1);
            chg_kind = $urandom_range(2);
            alt_len  = $urandom_range(255, chg_at);
        end

        for (int i = 0; i < count; i++) begin
            if (i == FLAGS_OFFSET)
                d = flags;
            else if (flags[FLAG_NAME] && i >= need && $urandom_range(7) != 0)
                d = 8'($urandom_range(PRINT_HI, PRINT_LO));
            else
                d = 8'($urandom);
            if (i >= chg_at && chg_kind == 0)
                add_byte(d, i == 0, 8'(plen), ptype ^ 4'($urandom_range(15, 1)), ver);
            else if (i >= chg_at && chg_kind == 1)
                add_byte(d, i == 0, 8'(plen), ptype, 2'($urandom));
            else if (i >= chg_at)
                add_byte(d, i == 0, 8'(alt_len), ptype, ver);
            else
                add_byte(d, i == 0, 8'(plen), ptype, ver);
        end
    endtask

    task automatic random_traffic(input int budget);
        int start;
        start = bytes_queued;
        while (bytes_queued - start < budget)
            queue_packet();
    endtask

    // Wait for every request to be taken and every result to arrive
    task automatic wait_drained();
        while (byte_queue.size() != 0 || i_valid || due_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [7:0] value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic apply_settings(input logic [3:0] ptype, input logic [1:0] ver,
                                  input logic bloom, input logic [7:0] nbuf);
        wait_drained();
        write_reg(CFG_ADVERT_TYPE, {4'd0, ptype});
        write_reg(CFG_EXT_VERSION, {6'd0, ver});
        write_reg(CFG_BLOOM_WANT, {7'd0, bloom});
        write_reg(CFG_NAME_BUF, nbuf);
        @(posedge i_clk);
        settings_used++;
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset settings
        queue_directed();
        random_traffic(PHASE_BYTES);

        // extremes, then a one-byte buffer, then random settings
        apply_settings(4'd15, 2'd3, 1'b1, 8'd255);
        random_traffic(PHASE_BYTES);
        apply_settings(4'd0, 2'd0, 1'b0, 8'd1);
        random_traffic(PHASE_BYTES);
        apply_settings(4'($urandom), 2'($urandom), 1'($urandom), 8'($urandom_range(40, 1)));
        random_traffic(PHASE_BYTES);

        wait_drained();
        repeat (END_CYCLES) @(posedge i_clk);

        $display("Run covered %0d payload bytes under %0d register settings,", bytes_taken,
                 settings_used);
        $display("checking %0d results of which %0d closed a packet.", results_checked,
                 statuses_seen);
        if (errors == 0 && due_results.size() == 0) begin
            $display("[advert_payload_parser] OK");
        end else begin
            $display("[advert_payload_parser] ERROR");
        end
        $finish;
    end

endmodule

/* filelist.f */
+incdir+rtl
rtl/advp_pkg.sv
rtl/advp_parse.sv
rtl/advp_queue.sv
rtl/advert_payload_parser.sv
dv/advert_payload_parser_test.sv
